// ----- hdl/grid_line_of_sight_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the grid line-of-sight block
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge while reset is low.
`define GLOS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Checked at every rising edge, reset included.
`define GLOS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define GLOS_ASSERT(label, clk, rst, prop)
`define GLOS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- hdl/glos_pkg.sv -----
// ----------------------------------------------------------------------------
// glos_pkg
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package glos_pkg;

  localparam int IN_W      = 6;
  localparam int MAP_ROWS  = 64;
  localparam int MAP_COLS  = 64;
  localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  // Walk coordinates are signed so that neighbors off the low edge are seen.
  localparam int COORD_W   = 8;
  // Width that holds any map dimension for the range compare.
  localparam int LIM_W     = 12;
  localparam int ACC_W     = 8;
  localparam int SEP_W     = 2 * IN_W + 1;
  localparam int T_W       = ACC_W + 3;
  localparam int PROD_W    = 2 * T_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Cell probed relative to the walk position, in major/minor axis terms.
  typedef enum logic [1:0] {
    OFS_HERE,
    OFS_SIDE,
    OFS_AHEAD,
    OFS_SIDE2
  } probe_sel_t;

  typedef struct packed {
    logic       clear_step;
    logic       map_write;
    logic       load_query;
    logic       setup;
    logic       probe;
    probe_sel_t probe_sel;
    logic       acc_add;
    logic       mul_t1;
    logic       mul_t2;
    logic       step_minor;
    logic       step_major;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic at_end;
    logic straight;
    logic err_over;
    logic prod_lt_sep;
    logic cell_hit;
  } status_t;

  function automatic logic in_map(input logic [COORD_W-1:0] r,
                                  input logic [COORD_W-1:0] c);
    in_map = !r[COORD_W-1] && !c[COORD_W-1] &&
             (LIM_W'(r) < LIM_W'(MAP_ROWS)) && (LIM_W'(c) < LIM_W'(MAP_COLS));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(MAP_COLS) + ADDR_W'(c);
  endfunction

endpackage

// ----- hdl/glos_ram.sv -----
// ----------------------------------------------------------------------------
// glos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/glos_datapath.sv -----
// ----------------------------------------------------------------------------
// glos_datapath
// Walk registers, error term, shared squarer and map address generation.
// ----------------------------------------------------------------------------
module glos_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  glos_pkg::cmd_t               cmd,
  output glos_pkg::status_t            status,
  input  logic [glos_pkg::IN_W-1:0]    row,
  input  logic [glos_pkg::IN_W-1:0]    col,
  input  logic                         cell_blocked,
  input  logic [glos_pkg::IN_W-1:0]    end_row,
  input  logic [glos_pkg::IN_W-1:0]    end_col,
  output logic                         map_we,
  output logic [glos_pkg::ADDR_W-1:0]  map_waddr,
  output logic                         map_wdata,
  output logic [glos_pkg::ADDR_W-1:0]  map_raddr,
  input  logic                         map_rdata
);

  logic [glos_pkg::IN_W-1:0]    start_row;
  logic [glos_pkg::IN_W-1:0]    start_col;
  logic [glos_pkg::IN_W-1:0]    stop_row;
  logic [glos_pkg::IN_W-1:0]    stop_col;
  logic                         row_major;
  logic                         smaj_pos;
  logic                         smin_pos;
  logic                         straight;
  logic [glos_pkg::IN_W-1:0]    dmaj;
  logic [glos_pkg::IN_W-1:0]    dmin;
  logic [glos_pkg::SEP_W-1:0]   sep;
  logic [glos_pkg::COORD_W-1:0] maj;
  logic [glos_pkg::COORD_W-1:0] mnr;
  logic [glos_pkg::COORD_W-1:0] maj_end;
  logic [glos_pkg::ACC_W-1:0]   acc;
  logic signed [glos_pkg::PROD_W-1:0] prod;
  logic                         probe_oob;
  logic [glos_pkg::ADDR_W-1:0]  clear_addr;

  logic [glos_pkg::IN_W:0]      diff_r;
  logic [glos_pkg::IN_W:0]      diff_c;
  logic [glos_pkg::IN_W-1:0]    dr;
  logic [glos_pkg::IN_W-1:0]    dc;
  logic                         row_major_c;
  logic [glos_pkg::COORD_W-1:0] step_maj;
  logic [glos_pkg::COORD_W-1:0] step_min;
  logic [glos_pkg::COORD_W-1:0] pmaj;
  logic [glos_pkg::COORD_W-1:0] pmnr;
  logic [glos_pkg::COORD_W-1:0] prow;
  logic [glos_pkg::COORD_W-1:0] pcol;
  logic signed [glos_pkg::T_W-1:0] t1;
  logic signed [glos_pkg::T_W-1:0] t2;
  logic signed [glos_pkg::T_W-1:0] mul_op;
  logic                         wr_ok;

  // Line setup from the latched end points.
  always_comb begin
    diff_r      = {1'b0, start_row} - {1'b0, stop_row};
    diff_c      = {1'b0, start_col} - {1'b0, stop_col};
    dr          = diff_r[glos_pkg::IN_W] ? glos_pkg::IN_W'(-diff_r)
                                         : diff_r[glos_pkg::IN_W-1:0];
    dc          = diff_c[glos_pkg::IN_W] ? glos_pkg::IN_W'(-diff_c)
                                         : diff_c[glos_pkg::IN_W-1:0];
    row_major_c = dr > dc;
  end

  // Probe address: the walk position moved along the major or minor axis.
  always_comb begin
    step_maj = smaj_pos ? glos_pkg::COORD_W'(1) : '1;
    step_min = smin_pos ? glos_pkg::COORD_W'(1) : '1;
    pmaj     = maj;
    pmnr     = mnr;
    unique case (cmd.probe_sel)
      glos_pkg::OFS_HERE:  ;
      glos_pkg::OFS_SIDE:  pmnr = mnr + step_min;
      glos_pkg::OFS_AHEAD: pmaj = maj + step_maj;
      glos_pkg::OFS_SIDE2: pmnr = mnr + (step_min << 1);
      default: ;
    endcase
    prow      = row_major ? pmaj : pmnr;
    pcol      = row_major ? pmnr : pmaj;
    map_raddr = glos_pkg::cell_addr(prow, pcol);
  end

  // Signed distances of the agent's edge from the two extra cells.
  always_comb begin
    t1 = (glos_pkg::T_W'(acc) <<< 1) - glos_pkg::T_W'(dmaj) - glos_pkg::T_W'(dmin);
    t2 = (glos_pkg::T_W'(dmaj) <<< 1) + glos_pkg::T_W'(dmaj) + glos_pkg::T_W'(dmin)
         - (glos_pkg::T_W'(acc) <<< 1);
    mul_op = cmd.mul_t2 ? t2 : t1;
  end

  // Map write port: clearing pass or a single cell write.
  always_comb begin
    wr_ok = glos_pkg::in_map(glos_pkg::COORD_W'(row), glos_pkg::COORD_W'(col));
    if (cmd.clear_step) begin
      map_we    = 1'b1;
      map_waddr = clear_addr;
      map_wdata = 1'b0;
    end else begin
      map_we    = cmd.map_write && wr_ok;
      map_waddr = glos_pkg::cell_addr(glos_pkg::COORD_W'(row), glos_pkg::COORD_W'(col));
      map_wdata = cell_blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + glos_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      start_row <= row;
      start_col <= col;
      stop_row  <= end_row;
      stop_col  <= end_col;
    end
    if (cmd.setup) begin
      row_major <= row_major_c;
      dmaj      <= row_major_c ? dr : dc;
      dmin      <= row_major_c ? dc : dr;
      smaj_pos  <= row_major_c ? diff_r[glos_pkg::IN_W] : diff_c[glos_pkg::IN_W];
      smin_pos  <= row_major_c ? diff_c[glos_pkg::IN_W] : diff_r[glos_pkg::IN_W];
      straight  <= (dr == '0) || (dc == '0);
      sep       <= glos_pkg::SEP_W'(dr) * glos_pkg::SEP_W'(dr)
                 + glos_pkg::SEP_W'(dc) * glos_pkg::SEP_W'(dc);
      maj       <= row_major_c ? glos_pkg::COORD_W'(start_row)
                               : glos_pkg::COORD_W'(start_col);
      mnr       <= row_major_c ? glos_pkg::COORD_W'(start_col)
                               : glos_pkg::COORD_W'(start_row);
      maj_end   <= row_major_c ? glos_pkg::COORD_W'(stop_row)
                               : glos_pkg::COORD_W'(stop_col);
      acc       <= '0;
    end
    if (cmd.probe) begin
      probe_oob <= !glos_pkg::in_map(prow, pcol);
    end
    if (cmd.acc_add) begin
      acc <= acc + glos_pkg::ACC_W'(dmin);
    end
    if (cmd.mul_t1 || cmd.mul_t2) begin
      prod <= mul_op * mul_op;
    end
    if (cmd.step_minor) begin
      mnr <= mnr + step_min;
      acc <= acc - glos_pkg::ACC_W'(dmaj);
    end
    if (cmd.step_major) begin
      maj <= maj + step_maj;
    end
  end

  always_comb begin
    status.clear_last  = clear_addr == glos_pkg::ADDR_W'(glos_pkg::MAP_DEPTH - 1);
    status.at_end      = maj == maj_end;
    status.straight    = straight;
    status.err_over    = acc > glos_pkg::ACC_W'(dmaj);
    status.prod_lt_sep = prod < $signed(glos_pkg::PROD_W'(sep));
    status.cell_hit    = probe_oob || map_rdata;
  end

endmodule

// ----- hdl/glos_ctrl.sv -----
// ----------------------------------------------------------------------------
// glos_ctrl
// Sequencer for map clearing, cell writes and the line walk.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_assert.svh"

module glos_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              opcode,
  input  glos_pkg::status_t status,
  output glos_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output logic              line_clear
);

  typedef enum logic [18:0] {
    S_CLEAR     = 19'h00001,
    S_IDLE      = 19'h00002,
    S_SETUP     = 19'h00004,
    S_LOOP      = 19'h00008,
    S_PRB_HERE  = 19'h00010,
    S_WT_HERE   = 19'h00020,
    S_PRB_SIDE  = 19'h00040,
    S_WT_SIDE   = 19'h00080,
    S_ACCUM     = 19'h00100,
    S_ERR       = 19'h00200,
    S_CMP1      = 19'h00400,
    S_PRB_AHEAD = 19'h00800,
    S_WT_AHEAD  = 19'h01000,
    S_MUL2      = 19'h02000,
    S_CMP2      = 19'h04000,
    S_PRB_SIDE2 = 19'h08000,
    S_WT_SIDE2  = 19'h10000,
    S_STEP_MNR  = 19'h20000,
    S_STEP_MAJ  = 19'h40000
  } state_t;

  state_t state;
  state_t state_next;
  logic   final_chk;
  logic   final_chk_next;
  logic   finish;
  logic   finish_clear;
  logic   accept_query;
  logic   accept_write;

  assign accept_query = start && !busy && (opcode == glos_pkg::OP_QUERY);
  assign accept_write = start && !busy && (opcode == glos_pkg::OP_WRITE);

  always_comb begin
    state_next     = state;
    final_chk_next = final_chk;
    cmd            = '0;
    finish         = 1'b0;
    finish_clear   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept_query) begin
          cmd.load_query = 1'b1;
          state_next     = S_SETUP;
        end else if (accept_write) begin
          cmd.map_write = 1'b1;
        end
      end
      S_SETUP: begin
        cmd.setup      = 1'b1;
        final_chk_next = 1'b0;
        state_next     = S_LOOP;
      end
      S_LOOP: begin
        if (status.at_end) begin
          if (status.straight) begin
            finish       = 1'b1;
            finish_clear = 1'b1;
          end else begin
            // Diagonal lines still check the end cell and its neighbor.
            final_chk_next = 1'b1;
            state_next     = S_PRB_HERE;
          end
        end else begin
          state_next = S_PRB_HERE;
        end
      end
      S_PRB_HERE: begin
        cmd.probe     = 1'b1;
        cmd.probe_sel = glos_pkg::OFS_HERE;
        state_next    = S_WT_HERE;
      end
      S_WT_HERE: begin
        if (status.cell_hit) begin
          finish = 1'b1;
        end else if (status.straight) begin
          state_next = S_STEP_MAJ;
        end else begin
          state_next = S_PRB_SIDE;
        end
      end
      S_PRB_SIDE: begin
        cmd.probe     = 1'b1;
        cmd.probe_sel = glos_pkg::OFS_SIDE;
        state_next    = S_WT_SIDE;
      end
      S_WT_SIDE: begin
        if (status.cell_hit) begin
          finish = 1'b1;
        end else if (final_chk) begin
          finish       = 1'b1;
          finish_clear = 1'b1;
        end else begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.acc_add = 1'b1;
        state_next  = S_ERR;
      end
      S_ERR: begin
        if (status.err_over) begin
          cmd.mul_t1 = 1'b1;
          state_next = S_CMP1;
        end else begin
          state_next = S_STEP_MAJ;
        end
      end
      S_CMP1: begin
        state_next = status.prod_lt_sep ? S_PRB_AHEAD : S_MUL2;
      end
      S_PRB_AHEAD: begin
        cmd.probe     = 1'b1;
        cmd.probe_sel = glos_pkg::OFS_AHEAD;
        state_next    = S_WT_AHEAD;
      end
      S_WT_AHEAD: begin
        if (status.cell_hit) begin
          finish = 1'b1;
        end else begin
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul_t2 = 1'b1;
        state_next = S_CMP2;
      end
      S_CMP2: begin
        state_next = status.prod_lt_sep ? S_PRB_SIDE2 : S_STEP_MNR;
      end
      S_PRB_SIDE2: begin
        cmd.probe     = 1'b1;
        cmd.probe_sel = glos_pkg::OFS_SIDE2;
        state_next    = S_WT_SIDE2;
      end
      S_WT_SIDE2: begin
        if (status.cell_hit) begin
          finish = 1'b1;
        end else begin
          state_next = S_STEP_MNR;
        end
      end
      S_STEP_MNR: begin
        cmd.step_minor = 1'b1;
        state_next     = S_STEP_MAJ;
      end
      S_STEP_MAJ: begin
        cmd.step_major = 1'b1;
        state_next     = S_LOOP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      final_chk <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      final_chk <= final_chk_next;
      done      <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      line_clear <= finish_clear;
    end
  end

  assign busy = state != S_IDLE;

  `GLOS_ASSERT_ALWAYS(a_reset_clears_map, clk, rst |=> busy)
  `GLOS_ASSERT(a_done_ends_walk, clk, rst, done |-> $past(state != S_IDLE))
  `GLOS_ASSERT(a_query_starts, clk, rst, accept_query |=> busy)
  `GLOS_ASSERT(a_write_silent, clk, rst, accept_write |=> (!busy && !done))

endmodule

// ----- hdl/grid_line_of_sight.sv -----
// Cell write: busy stays low, no result beat; next item in the next cycle.
// Query: busy from the accept until done; done is a registered pulse in the cycle after the walk ends.
// Query time grows with the major-axis length of the line; a diagonal line also checks its end cells.
// The walk is paced by the single registered map read port.
// Reset: a clearing pass writes every map cell free (busy high).
// ----------------------------------------------------------------------------
// grid_line_of_sight
// Occupancy map with a Bresenham band walk that answers clear or blocked.
// ----------------------------------------------------------------------------
module grid_line_of_sight (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode,
  input  logic [glos_pkg::IN_W-1:0] row,
  input  logic [glos_pkg::IN_W-1:0] col,
  input  logic                      cell_blocked,
  input  logic [glos_pkg::IN_W-1:0] end_row,
  input  logic [glos_pkg::IN_W-1:0] end_col,
  output logic                      done,
  output logic                      line_clear
);

  glos_pkg::cmd_t              cmd;
  glos_pkg::status_t           status;
  logic                        map_we;
  logic [glos_pkg::ADDR_W-1:0] map_waddr;
  logic                        map_wdata;
  logic [glos_pkg::ADDR_W-1:0] map_raddr;
  logic                        map_rdata;

  glos_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done),
    .line_clear (line_clear)
  );

  glos_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .row          (row),
    .col          (col),
    .cell_blocked (cell_blocked),
    .end_row      (end_row),
    .end_col      (end_col),
    .map_we       (map_we),
    .map_waddr    (map_waddr),
    .map_wdata    (map_wdata),
    .map_raddr    (map_raddr),
    .map_rdata    (map_rdata)
  );

  glos_ram #(
    .WIDTH (1),
    .DEPTH (glos_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-of-sight testbench
// Drives map writes and line queries through the start/busy handshake and
// predicts every answer from its own copy of the occupancy map and its own
// band walk. Each done beat is compared with the oldest predicted answer.
// ----------------------------------------------------------------------------
module testbench;

  logic                        clk;
  logic                        rst          = 1'b1;
  logic                        start        = 1'b0;
  logic                        busy;
  logic                        opcode       = glos_pkg::OP_WRITE;
  logic [glos_pkg::IN_W-1:0]   row          = '0;
  logic [glos_pkg::IN_W-1:0]   col          = '0;
  logic                        cell_blocked = 1'b0;
  logic [glos_pkg::IN_W-1:0]   end_row      = '0;
  logic [glos_pkg::IN_W-1:0]   end_col      = '0;
  logic                        done;
  logic                        line_clear;

  bit                occ_map [glos_pkg::MAP_DEPTH];
  bit                expected_clear [$];
  int                mismatch_count = 0;
  int                n_writes       = 0;
  int                n_queries      = 0;
  int                n_clear        = 0;
  int                n_blocked      = 0;
  bit                burst_stretch  = 1'b0;

  grid_line_of_sight dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .row          (row),
    .col          (col),
    .cell_blocked (cell_blocked),
    .end_row      (end_row),
    .end_col      (end_col),
    .done         (done),
    .line_clear   (line_clear)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Cells beyond any edge of the map count as walls.
  function automatic bit cell_is_wall(input int r, input int c);
    if (r < 0 || r >= glos_pkg::MAP_ROWS || c < 0 || c >= glos_pkg::MAP_COLS) return 1'b1;
    return occ_map[r * glos_pkg::MAP_COLS + c];
  endfunction

  function automatic bit predict_clear(input int r1, input int c1,
                                       input int r2, input int c2);
    int dr, dc, sr, sc, sep, t, pos_r, pos_c, err;
    dr = (r1 > r2) ? r1 - r2 : r2 - r1;
    dc = (c1 > c2) ? c1 - c2 : c2 - c1;
    sr = (r1 < r2) ? 1 : -1;
    sc = (c1 < c2) ? 1 : -1;
    sep = dr * dr + dc * dc;
    pos_r = r1;
    pos_c = c1;
    err = 0;
    if (dr == 0) begin
      while (pos_c != c2) begin
        if (cell_is_wall(pos_r, pos_c)) return 1'b0;
        pos_c += sc;
      end
    end else if (dc == 0) begin
      while (pos_r != r2) begin
        if (cell_is_wall(pos_r, pos_c)) return 1'b0;
        pos_r += sr;
      end
    end else if (dr > dc) begin
      while (pos_r != r2) begin
        if (cell_is_wall(pos_r, pos_c) || cell_is_wall(pos_r, pos_c + sc)) return 1'b0;
        err += dc;
        if (err > dr) begin
          t = 2 * err - dr - dc;
          if (t * t < sep && cell_is_wall(pos_r + sr, pos_c)) return 1'b0;
          t = 3 * dr - (2 * err - dc);
          if (t * t < sep && cell_is_wall(pos_r, pos_c + 2 * sc)) return 1'b0;
          pos_c += sc;
          err -= dr;
        end
        pos_r += sr;
      end
      if (cell_is_wall(pos_r, pos_c) || cell_is_wall(pos_r, pos_c + sc)) return 1'b0;
    end else begin
      while (pos_c != c2) begin
        if (cell_is_wall(pos_r, pos_c) || cell_is_wall(pos_r + sr, pos_c)) return 1'b0;
        err += dr;
        if (err > dc) begin
          t = 2 * err - dr - dc;
          if (t * t < sep && cell_is_wall(pos_r, pos_c + sc)) return 1'b0;
          t = 3 * dc - (2 * err - dr);
          if (t * t < sep && cell_is_wall(pos_r + 2 * sr, pos_c)) return 1'b0;
          pos_r += sr;
          err -= dc;
        end
        pos_c += sc;
      end
      if (cell_is_wall(pos_r, pos_c) || cell_is_wall(pos_r + sr, pos_c)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [glos_pkg::IN_W-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > glos_pkg::MAP_ROWS - 1) return glos_pkg::IN_W'(glos_pkg::MAP_ROWS - 1);
    return glos_pkg::IN_W'(v);
  endfunction

  // Start stays high across back-to-back beats; it only drops for a gap or a drain wait.
  task automatic send_item(input logic op, input logic [glos_pkg::IN_W-1:0] r,
                           input logic [glos_pkg::IN_W-1:0] c, input logic blk,
                           input logic [glos_pkg::IN_W-1:0] er,
                           input logic [glos_pkg::IN_W-1:0] ec);
    int gap;
    gap = burst_stretch ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    row          <= r;
    col          <= c;
    cell_blocked <= blk;
    end_row      <= er;
    end_col      <= ec;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == glos_pkg::OP_WRITE) begin
      occ_map[int'(r) * glos_pkg::MAP_COLS + int'(c)] = blk;
      n_writes++;
    end else begin
      expected_clear = {expected_clear, predict_clear(r, c, er, ec)};
      n_queries++;
    end
  endtask

  task automatic write_cell(input int r, input int c, input bit blk);
    send_item(glos_pkg::OP_WRITE, glos_pkg::IN_W'(r), glos_pkg::IN_W'(c), blk,
              glos_pkg::IN_W'($urandom), glos_pkg::IN_W'($urandom));
  endtask

  task automatic query_line(input int r1, input int c1, input int r2, input int c2);
    send_item(glos_pkg::OP_QUERY, glos_pkg::IN_W'(r1), glos_pkg::IN_W'(c1), 1'($urandom),
              glos_pkg::IN_W'(r2), glos_pkg::IN_W'(c2));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_clear.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_beat
    bit want;
    if (!rst && done) begin
      if (expected_clear.size() == 0) begin
        $error("line_clear: result beat with nothing expected, actual %0b", line_clear);
        mismatch_count++;
      end else begin
        want = expected_clear.pop_front();
        if (line_clear !== want) begin
          $error("line_clear: expected %0b, actual %0b", want, line_clear);
          mismatch_count++;
        end
        if (line_clear) n_clear++;
        else n_blocked++;
      end
    end
  end

  // Reset map: single cell, straight lines, corner-to-corner diagonals and two inner diagonals.
  task automatic test_empty_map();
    query_line(0, 0, 0, 0);
    query_line(0, 0, 0, 63);
    query_line(63, 0, 0, 0);
    query_line(0, 0, 63, 63);
    query_line(63, 63, 0, 0);
    query_line(0, 63, 63, 0);
    query_line(10, 10, 40, 20);
    query_line(20, 5, 25, 40);
  endtask

  // The end cell of a straight line is never looked at, the start cell is.
  task automatic test_obstacles();
    write_cell(0, 0, 1'b1);
    write_cell(63, 63, 1'b1);
    write_cell(25, 15, 1'b1);
    query_line(63, 63, 63, 0);
    query_line(63, 0, 63, 63);
    query_line(0, 5, 0, 0);
    query_line(0, 0, 5, 0);
    query_line(10, 10, 40, 20);
    query_line(24, 10, 27, 20);
    write_cell(0, 0, 1'b0);
    write_cell(63, 63, 1'b0);
    write_cell(25, 15, 1'b0);
  endtask

  // The sender holds off until every answer is back.
  task automatic test_drain_pause();
    query_line(5, 5, 9, 30);
    query_line(40, 40, 30, 60);
    wait_drained();
    query_line(62, 1, 1, 62);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int base_r, base_c, kind, r, c;
    base_r = 0;
    base_c = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: begin base_r = 0; base_c = 0; end
          1: begin base_r = 52; base_c = 52; end
          default: begin
            base_r = $urandom_range(0, 52);
            base_c = $urandom_range(0, 52);
          end
        endcase
      end
      if (i % 20 == 0) burst_stretch = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      r = base_r + $urandom_range(0, 11);
      c = base_c + $urandom_range(0, 11);
      if (kind < 45) begin
        write_cell(r, c, $urandom_range(0, 99) < 40);
      end else if (kind < 85) begin
        query_line(r, c, clamp_coord(r + $urandom_range(0, 18) - 9),
                   clamp_coord(c + $urandom_range(0, 18) - 9));
      end else if (kind < 92) begin
        query_line($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (kind < 96) begin
        if ($urandom_range(0, 1))
          query_line(r, c, r, clamp_coord(c + $urandom_range(0, 30) - 15));
        else
          query_line(r, c, clamp_coord(r + $urandom_range(0, 30) - 15), c);
      end else begin
        write_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 2) wait_drained();
    end
    burst_stretch = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_map();
    test_obstacles();
    test_drain_pause();
    test_random_traffic(550);
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Covered %0d map writes and %0d line queries (edge, straight, diagonal).",
             n_writes, n_queries);
    $display("Answers seen: %0d clear, %0d blocked.", n_clear, n_blocked);
    if (mismatch_count == 0 && expected_clear.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
